>>> src/assert_macros.svh
// Assertion macros for the deque RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked property with a reset that disables the check.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

>>> src/bdq_pkg.sv
// Shared types, request codes and constants of the bounded deque.
// No dependencies.
package bdq_pkg;

  localparam int DEPTH_DEFAULT      = 1024;
  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int CAP_W              = 11;
  localparam int REQ_W              = 3;
  localparam int FIELD_W            = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [REQ_W-1:0] REQ_NONE       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd4;

  localparam logic signed [FIELD_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [FIELD_W-1:0] push_value;
  } bdq_req_t;

  typedef struct packed {
    logic                      accepted;
    logic signed [FIELD_W-1:0] front_value;
    logic signed [FIELD_W-1:0] rear_value;
    logic                      empty_flag;
    logic                      full_flag;
  } bdq_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RD_FRONT,
    ST_RD_REAR,
    ST_LOAD
  } bdq_state_t;

  typedef struct packed {
    logic latch;
    logic update;
    logic rd_front;
    logic rd_rear;
    logic load;
  } bdq_cmd_t;

  typedef struct packed {
    logic out_free;
  } bdq_sts_t;

endpackage

>>> src/bdq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/bdq_ctrl.sv
// Request sequencer of the bounded deque.
// Depends on bdq_pkg (state, command and status types).
module bdq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  bdq_pkg::bdq_sts_t   sts,
  output logic                req_stall,
  output bdq_pkg::bdq_cmd_t   cmd
);

  bdq_pkg::bdq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      bdq_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = bdq_pkg::ST_UPDATE;
        end
      end
      bdq_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = bdq_pkg::ST_RD_FRONT;
      end
      bdq_pkg::ST_RD_FRONT: begin
        cmd.rd_front = 1'b1;
        state_next   = bdq_pkg::ST_RD_REAR;
      end
      bdq_pkg::ST_RD_REAR: begin
        cmd.rd_rear = 1'b1;
        state_next  = bdq_pkg::ST_LOAD;
      end
      bdq_pkg::ST_LOAD: begin
        // hold until the output register can take the word
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = bdq_pkg::ST_IDLE;
        end
      end
      default: state_next = bdq_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> src/bdq_datapath.sv
// Ring indices, occupancy, capacity register, entry RAM and output register.
// Depends on bdq_pkg, bdq_ram and assert_macros.svh.
`include "assert_macros.svh"
module bdq_datapath #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bdq_pkg::bdq_cmd_t             cmd,
  output bdq_pkg::bdq_sts_t             sts,
  input  bdq_pkg::bdq_req_t             req,
  input  logic                          cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]     cfg_data,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output bdq_pkg::bdq_rsp_t             rsp
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW   = $clog2(DEPTH + 1);
  localparam int CMPW = (OW > bdq_pkg::CAP_W) ? OW : bdq_pkg::CAP_W;
  localparam logic [AW-1:0]   LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(DEPTH);

  logic [bdq_pkg::REQ_W-1:0]   req_type_q;
  logic [DATA_WIDTH-1:0]       push_q;
  logic [AW-1:0]               front_index, front_index_next;
  logic [AW-1:0]               rear_index, rear_index_next;
  logic [OW-1:0]               occupancy, occupancy_next;
  logic [bdq_pkg::CAP_W-1:0]   capacity;
  logic                        ok, ok_next;
  logic [DATA_WIDTH-1:0]       front_q;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;
  logic [DATA_WIDTH-1:0]       rd_data;

  logic [CMPW-1:0]             cap_ext, eff_cap, occ_ext;
  logic                        has_room, is_empty;
  logic [AW-1:0]               front_prev, front_succ, rear_prev, rear_succ;
  logic signed [DATA_WIDTH-1:0] front_s, rear_s;
  logic signed [63:0]           front_w, rear_w;
  bdq_pkg::bdq_rsp_t            rsp_next;

  assign front_prev = (front_index == '0) ? LAST_SLOT : front_index - AW'(1);
  assign front_succ = (front_index == LAST_SLOT) ? '0 : front_index + AW'(1);
  assign rear_prev  = (rear_index == '0) ? LAST_SLOT : rear_index - AW'(1);
  assign rear_succ  = (rear_index == LAST_SLOT) ? '0 : rear_index + AW'(1);

  // effective capacity saturates at the ring depth
  assign cap_ext  = CMPW'(capacity);
  assign eff_cap  = (cap_ext > DEPTH_CMP) ? DEPTH_CMP : cap_ext;
  assign occ_ext  = CMPW'(occupancy);
  assign has_room = occ_ext < eff_cap;
  assign is_empty = occupancy == '0;

  always_comb begin
    front_index_next = front_index;
    rear_index_next  = rear_index;
    occupancy_next   = occupancy;
    ok_next          = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = rear_index;
    case (req_type_q)
      bdq_pkg::REQ_NONE: ok_next = 1'b1;
      bdq_pkg::REQ_PUSH_FRONT: begin
        if (has_room) begin
          front_index_next = front_prev;
          wr_en            = cmd.update;
          wr_addr          = front_prev;
          occupancy_next   = occupancy + OW'(1);
          ok_next          = 1'b1;
        end
      end
      bdq_pkg::REQ_PUSH_REAR: begin
        if (has_room) begin
          rear_index_next = rear_succ;
          wr_en           = cmd.update;
          wr_addr         = rear_index;
          occupancy_next  = occupancy + OW'(1);
          ok_next         = 1'b1;
        end
      end
      bdq_pkg::REQ_POP_FRONT: begin
        if (!is_empty) begin
          front_index_next = front_succ;
          occupancy_next   = occupancy - OW'(1);
          ok_next          = 1'b1;
        end
      end
      bdq_pkg::REQ_POP_REAR: begin
        if (!is_empty) begin
          rear_index_next = rear_prev;
          occupancy_next  = occupancy - OW'(1);
          ok_next         = 1'b1;
        end
      end
      default: ok_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      rear_index  <= '0;
      occupancy   <= '0;
      capacity    <= bdq_pkg::CAP_RESET;
    end else begin
      if (cmd.update) begin
        front_index <= front_index_next;
        rear_index  <= rear_index_next;
        occupancy   <= occupancy_next;
      end
      // drop capacity writes while entries are held
      if (cfg_we && is_empty) begin
        capacity <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_type_q <= req.req_type;
      push_q     <= DATA_WIDTH'(req.push_value);
    end
    if (cmd.update) begin
      ok <= ok_next;
    end
    if (cmd.rd_rear) begin
      front_q <= rd_data;
    end
  end

  assign rd_addr = cmd.rd_front ? front_index : rear_prev;

  bdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_q),
    .rd_en   (cmd.rd_front | cmd.rd_rear),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sign-extend stored words, keep the low field bits
  assign front_s = front_q;
  assign rear_s  = rd_data;
  assign front_w = 64'(front_s);
  assign rear_w  = 64'(rear_s);

  always_comb begin
    rsp_next.accepted    = ok;
    rsp_next.empty_flag  = is_empty;
    rsp_next.full_flag   = occ_ext >= eff_cap;
    rsp_next.front_value = is_empty ? bdq_pkg::EMPTY_VALUE : front_w[bdq_pkg::FIELD_W-1:0];
    rsp_next.rear_value  = is_empty ? bdq_pkg::EMPTY_VALUE : rear_w[bdq_pkg::FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp <= rsp_next;
    end
  end

  assign sts.out_free = !rsp_valid || !rsp_stall;

  `ASSERT_NEVER(a_occ_bound, clk, rst, occ_ext > DEPTH_CMP, "occupancy above ring depth")
  `ASSERT_CLK(a_empty_idx, clk, rst, is_empty |-> front_index == rear_index, "empty ring with split indices")
  `ASSERT_CLK(a_empty_rsp, clk, rst, rsp_valid && rsp.empty_flag |-> rsp.front_value == bdq_pkg::EMPTY_VALUE && rsp.rear_value == bdq_pkg::EMPTY_VALUE, "empty word carries values")
  `ASSERT_CLK(a_load_free, clk, rst, cmd.load |-> !rsp_valid || !rsp_stall, "output word overwritten while stalled")

endmodule

>>> src/bounded_double_ended_queue_core.sv
// Top level of the bounded double-ended queue: sequencer plus datapath.
// Depends on bdq_pkg, bdq_ctrl, bdq_datapath (and through it bdq_ram).
//
//  channel   direction  handshake             word
//  req       in         req_valid/req_stall   bdq_req_t: req_type, push_value
//  rsp       out        rsp_valid/rsp_stall   bdq_rsp_t: accepted, front/rear, flags
//  cfg       in         cfg_we                capacity (11 bits), no read-back
//
// Each request steps through accept, index update with the ring write,
// then two reads through the single RAM read port (front, then rear),
// then the load into the output register.
// A stalled result holds the sequencer in its load step; a request can be
// accepted while the previous result still waits.
// Reset is synchronous: indices and occupancy clear, capacity returns to
// 1024; the ring RAM needs no clearing pass.
module bounded_double_ended_queue_core #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  bdq_pkg::bdq_req_t          req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output bdq_pkg::bdq_rsp_t          rsp,
  input  logic                       cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]  cfg_data
);

  // command and status between sequencer and datapath
  bdq_pkg::bdq_cmd_t cmd;
  bdq_pkg::bdq_sts_t sts;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  // hold indices, occupancy, capacity, ring and the output word
  bdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
